@@ sv/sirt_pkg.sv @@
// Shared types, widths and codes of the sorted interval reservation table.
package sirt_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned TIME_W   = 11;
  localparam int unsigned ROOM_W   = 16;
  localparam int unsigned STAT_W   = 3;

  localparam logic [TIME_W-1:0] DAY_MINUTES = TIME_W'(1440);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERLAP   = 3'd1,
    ST_FULL      = 3'd2,
    ST_INVALID   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_e;

  typedef struct packed {
    logic [TIME_W-1:0] start_min;
    logic [TIME_W-1:0] end_min;
    logic [ROOM_W-1:0] room;
  } entry_t;

  typedef struct packed {
    logic overlap;  // new interval overlaps the stored one
    logic later;    // stored start is above the new start
    logic same;     // stored start equals the new start
  } cmp_t;

endpackage

@@ sv/sirt_if.sv @@
// Handshake channels of the sorted interval reservation table.
interface sirt_req_if;
  logic                           valid;
  logic                           ready;
  logic [sirt_pkg::MODE_W-1:0]    mode;
  logic [sirt_pkg::TIME_W-1:0]    start_time;
  logic [sirt_pkg::TIME_W-1:0]    end_time;
  logic [sirt_pkg::ROOM_W-1:0]    room_tag;
  logic [sirt_pkg::IDX_W-1:0]     read_index;

  modport source (output valid, mode, start_time, end_time, room_tag, read_index,
                  input ready);
  modport sink (input valid, mode, start_time, end_time, room_tag, read_index,
                output ready);
endinterface

interface sirt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sirt_pkg::STAT_W-1:0]    status;
  logic [sirt_pkg::IDX_W-1:0]     position;
  logic [sirt_pkg::TIME_W-1:0]    entry_start;
  logic [sirt_pkg::TIME_W-1:0]    entry_end;
  logic [sirt_pkg::ROOM_W-1:0]    entry_room;
  logic [sirt_pkg::CNT_W-1:0]     entry_total;

  modport source (output valid, status, position, entry_start, entry_end, entry_room,
                  entry_total, input ready);
  modport sink (input valid, status, position, entry_start, entry_end, entry_room,
                entry_total, output ready);
endinterface

interface sirt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sirt_pkg::CNT_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/sirt_cmp.sv @@
// Compares one stored interval against the interval of the item in work.
module sirt_cmp (
  input  sirt_pkg::entry_t                entry_i,
  input  logic [sirt_pkg::TIME_W-1:0]     start_i,
  input  logic [sirt_pkg::TIME_W-1:0]     end_i,
  output sirt_pkg::cmp_t                  flags_o
);
  import sirt_pkg::*;

  // Touching intervals do not overlap, so both tests are strict.
  assign flags_o.overlap = (start_i < entry_i.end_min) && (end_i > entry_i.start_min);
  assign flags_o.later   = entry_i.start_min > start_i;
  assign flags_o.same    = entry_i.start_min == start_i;

endmodule

@@ sv/sorted_interval_reservation_table.sv @@
// Sorted interval reservation table: up to CAPACITY intervals held in one
// synchronous memory, sorted by start, with insert, remove-by-start and read.
// One item is worked on at a time and the memory port moves one entry per
// cycle. An item is accepted in S_IDLE and loads the result register in
// S_DONE. Between those, an insert or a remove scans all stored entries and
// then, unless it is refused, moves the entries that must make room or close
// the gap. An insert moves the count - position entries at and after its
// place up. A remove moves the count - position - 1 entries above the gap
// down. A read fetches its entry through the registered memory read. An
// invalid insert, a read beyond the count and the unused mode go straight to
// the result register. An insert is refused as full only after its scan. The
// next item may be accepted while a result still waits, and a second finished
// item holds the input until the first is taken. The capacity register may be
// written at any time the block is idle.
module sorted_interval_reservation_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  sirt_req_if.sink   req_i,
  sirt_rsp_if.source rsp_o,
  sirt_cfg_if.sink   cfg_i
);
  import sirt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic               is_ins_q, is_ins_d;
  logic [TIME_W-1:0]  s_q, s_d;
  logic [TIME_W-1:0]  e_q, e_d;
  logic [ROOM_W-1:0]  room_q, room_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   cap_q;
  logic [CNT_W-1:0]   addr_q, addr_d;
  logic [CNT_W-1:0]   left_q, left_d;
  logic               ovl_q, ovl_d;
  logic               hit_q, hit_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  entry_t             rd_data_q;
  status_e            res_st_q, res_st_d;
  logic [IDX_W-1:0]   res_pos_q, res_pos_d;
  entry_t             res_ent_q, res_ent_d;
  logic               out_vld_q, out_vld_d;
  logic               out_load;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  entry_t             mem_wd;
  entry_t             mem [CAPACITY];

  logic [CNT_W-1:0]   limit;
  logic [IDX_W-1:0]   ins_pos;
  cmp_t               flags;

  assign limit = (cap_q > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : cap_q;
  assign ins_pos = hit_q ? pos_q : cnt_q[IDX_W-1:0];

  sirt_cmp u_cmp (
    .entry_i (rd_data_q),
    .start_i (s_q),
    .end_i   (e_q),
    .flags_o (flags)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_vld_q;

  always_comb begin
    state_d   = state_q;
    is_ins_d  = is_ins_q;
    s_d       = s_q;
    e_d       = e_q;
    room_d    = room_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    left_d    = left_q;
    ovl_d     = ovl_q;
    hit_d     = hit_q;
    pos_d     = pos_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    res_st_d  = res_st_q;
    res_pos_d = res_pos_q;
    res_ent_d = res_ent_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = rd_data_q;
    out_load  = 1'b0;
    out_vld_d = out_vld_q && !rsp_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          s_d       = req_i.start_time;
          e_d       = req_i.end_time;
          room_d    = req_i.room_tag;
          is_ins_d  = (req_i.mode == MODE_INSERT);
          ovl_d     = 1'b0;
          hit_d     = 1'b0;
          pos_d     = '0;
          addr_d    = '0;
          res_pos_d = '0;
          res_ent_d = '0;
          unique case (req_i.mode)
            MODE_INSERT: begin
              if ((req_i.end_time > DAY_MINUTES) || (req_i.end_time < req_i.start_time)) begin
                res_st_d = ST_INVALID;
                state_d  = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            MODE_REMOVE: begin
              state_d = S_SCAN;
            end
            MODE_READ: begin
              res_pos_d = req_i.read_index;
              if (CNT_W'(req_i.read_index) >= cnt_q) begin
                res_st_d = ST_BAD_INDEX;
                state_d  = S_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = req_i.read_index;
                state_d = S_READ;
              end
            end
            default: begin
              res_st_d = ST_OK;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // One read issued per cycle; its data is compared in the next cycle.
        if (addr_q < cnt_q) begin
          rd_en    = 1'b1;
          rd_addr  = addr_q[IDX_W-1:0];
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q[IDX_W-1:0];
          addr_d   = addr_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          if (is_ins_q && flags.overlap) begin
            ovl_d = 1'b1;
          end
          if (!hit_q && (is_ins_q ? flags.later : flags.same)) begin
            hit_d = 1'b1;
            pos_d = rd_idx_q;
          end
        end else if (addr_q == cnt_q) begin
          if (is_ins_q) begin
            if (ovl_q) begin
              res_st_d = ST_OVERLAP;
              state_d  = S_DONE;
            end else if (cnt_q >= limit) begin
              res_st_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              pos_d   = ins_pos;
              left_d  = cnt_q - CNT_W'(ins_pos);
              addr_d  = cnt_q - CNT_W'(1);
              state_d = S_SHIFT;
            end
          end else begin
            if (!hit_q) begin
              res_st_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end else begin
              left_d  = cnt_q - CNT_W'(1) - CNT_W'(pos_q);
              addr_d  = CNT_W'(pos_q) + CNT_W'(1);
              state_d = S_SHIFT;
            end
          end
        end
      end

      S_SHIFT: begin
        // Inserts move entries up from the top down; removes move them down
        // from the gap up, so a read never meets a pending write.
        if (left_q != '0) begin
          rd_en    = 1'b1;
          rd_addr  = addr_q[IDX_W-1:0];
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q[IDX_W-1:0];
          addr_d   = is_ins_q ? (addr_q - CNT_W'(1)) : (addr_q + CNT_W'(1));
          left_d   = left_q - CNT_W'(1);
        end
        if (rd_vld_q) begin
          mem_we = 1'b1;
          mem_wa = is_ins_q ? (rd_idx_q + IDX_W'(1)) : (rd_idx_q - IDX_W'(1));
          mem_wd = rd_data_q;
        end else if (left_q == '0) begin
          if (is_ins_q) begin
            mem_we = 1'b1;
            mem_wa = pos_q;
            mem_wd = '{start_min: s_q, end_min: e_q, room: room_q};
            cnt_d  = cnt_q + CNT_W'(1);
          end else begin
            cnt_d  = cnt_q - CNT_W'(1);
          end
          res_st_d  = ST_OK;
          res_pos_d = pos_q;
          state_d   = S_DONE;
        end
      end

      S_READ: begin
        res_st_d  = ST_OK;
        res_ent_d = rd_data_q;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      cap_q     <= CNT_W'(16);
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) begin
        cap_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    is_ins_q  <= is_ins_d;
    s_q       <= s_d;
    e_q       <= e_d;
    room_q    <= room_d;
    addr_q    <= addr_d;
    left_q    <= left_d;
    ovl_q     <= ovl_d;
    hit_q     <= hit_d;
    pos_q     <= pos_d;
    rd_idx_q  <= rd_idx_d;
    res_st_q  <= res_st_d;
    res_pos_q <= res_pos_d;
    res_ent_q <= res_ent_d;
    if (out_load) begin
      rsp_o.status      <= res_st_q;
      rsp_o.position    <= res_pos_q;
      rsp_o.entry_start <= res_ent_q.start_min;
      rsp_o.entry_end   <= res_ent_q.end_min;
      rsp_o.entry_room  <= res_ent_q.room;
      rsp_o.entry_total <= cnt_q;
    end
  end

  // Interval store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule
